// ===== sv/srse_pkg.sv =====
// ----------------------------------------------------------------------------
// srse_pkg
// Shared widths, register indexes and the segment type of the serpentine
// run segment extractor.
// ----------------------------------------------------------------------------
package srse_pkg;

    localparam int ROW_IDX_W   = 10;
    localparam int COL_OUT_W   = 5;
    localparam int CFG_COLS_W  = 6;
    localparam int CFG_ROWS_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_BITS_W   = 32;
    localparam int MAX_SEGS    = 16;
    localparam int SEG_CNT_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 6'd30;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 11'd8;
    localparam logic [CFG_ROWS_W-1:0] ROWS_MAX   = 11'd1024;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COLUMNS = 1'b0;
    localparam t_cfg_idx CFG_ROWS    = 1'b1;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_OUT_W-1:0] start_col;
        logic [COL_OUT_W-1:0] end_col;
        logic                 last_segment;
    } t_seg;

endpackage

// ===== sv/srse_queue.sv =====
// ----------------------------------------------------------------------------
// srse_queue
// Small register queue that decouples the row classifier from the extractor.
// ----------------------------------------------------------------------------
module srse_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== sv/srse_front.sv =====
// ----------------------------------------------------------------------------
// srse_front
// Holds configuration and the row counter, masks each row to the valid
// columns and puts it into scan order for the extractor.
// ----------------------------------------------------------------------------
module srse_front
    import srse_pkg::*;
#(
    parameter int ROW_WIDTH = 32,
    parameter int EW        = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [IN_BITS_W-1:0]  i_row_bits,
    output logic                  o_q_push,
    output logic [ROW_WIDTH-1:0]  o_vec,
    output logic                  o_rev,
    output logic [EW-1:0]         o_cols,
    output logic [ROW_IDX_W-1:0]  o_row
);

    localparam int CMW = (EW > CFG_COLS_W) ? EW : CFG_COLS_W;

    logic [CFG_COLS_W-1:0] r_cols_cfg;
    logic [CFG_ROWS_W-1:0] r_rows_cfg;
    logic [ROW_IDX_W-1:0]  r_row;
    logic                  r_rev;

    logic [CMW-1:0]        cols_ext;
    logic [CMW-1:0]        cols_lim;
    logic [EW-1:0]         cols_eff;
    logic [ROW_WIDTH-1:0]  masked;
    logic [ROW_WIDTH-1:0]  flipped;
    logic [ROW_WIDTH-1:0]  scan_vec;
    logic [CFG_ROWS_W-1:0] rows_eff;
    logic [CFG_ROWS_W-1:0] next_row;

    assign cols_ext = CMW'(r_cols_cfg);
    assign cols_lim = CMW'(ROW_WIDTH);
    assign cols_eff = (cols_ext > cols_lim) ? EW'(cols_lim) : EW'(cols_ext);
    assign masked   = ROW_WIDTH'(i_row_bits) & ~({ROW_WIDTH{1'b1}} << cols_eff);

    always_comb begin
        for (int i = 0; i < ROW_WIDTH; i++) begin
            flipped[i] = masked[ROW_WIDTH-1-i];
        end
    end

    // In reverse scan, position k of the vector is column cols-1-k.
    assign scan_vec = r_rev ? (flipped >> (EW'(ROW_WIDTH) - cols_eff)) : masked;

    always_comb begin
        priority if (r_rows_cfg == '0) begin
            rows_eff = CFG_ROWS_W'(1);
        end else if (r_rows_cfg > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = r_rows_cfg;
        end
    end

    assign next_row = CFG_ROWS_W'(r_row) + CFG_ROWS_W'(1);

    assign o_q_push = i_accept && (masked != '0);
    assign o_vec    = scan_vec;
    assign o_rev    = r_rev;
    assign o_cols   = cols_eff;
    assign o_row    = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
            r_row      <= '0;
            r_rev      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COLUMNS: r_cols_cfg <= i_cfg_data[CFG_COLS_W-1:0];
                    CFG_ROWS:    r_rows_cfg <= i_cfg_data[CFG_ROWS_W-1:0];
                    default:     r_rows_cfg <= r_rows_cfg;
                endcase
            end
            if (i_accept) begin
                if (next_row >= rows_eff) begin
                    r_row <= '0;
                    r_rev <= 1'b0;
                end else begin
                    r_row <= next_row[ROW_IDX_W-1:0];
                    r_rev <= !r_rev;
                end
            end
        end
    end

endmodule

// ===== sv/srse_back.sv =====
// ----------------------------------------------------------------------------
// srse_back
// Peels one run per cycle off a scan-ordered row, while the output register
// is empty or being popped, and presents it as a segment in that register.
// ----------------------------------------------------------------------------
module srse_back
    import srse_pkg::*;
#(
    parameter int ROW_WIDTH = 32,
    parameter int EW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  logic [ROW_WIDTH-1:0] i_vec,
    input  logic                 i_rev,
    input  logic [EW-1:0]        i_cols,
    input  logic [ROW_IDX_W-1:0] i_row,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output t_seg                 o_seg
);

    localparam int MW = (EW > COL_OUT_W) ? EW : COL_OUT_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state               r_state;
    logic [ROW_WIDTH-1:0] r_vec;
    logic                 r_rev;
    logic [EW-1:0]        r_cols;
    logic [ROW_IDX_W-1:0] r_row;
    logic [SEG_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    t_seg                 r_out;

    logic                 take;
    logic                 step;
    logic [ROW_WIDTH-1:0] src;
    logic                 src_rev;
    logic [EW-1:0]        src_cols;
    logic [ROW_IDX_W-1:0] src_row;
    logic [SEG_CNT_W-1:0] src_cnt;
    logic [ROW_WIDTH-1:0] low_bit;
    logic [ROW_WIDTH:0]   sum;
    logic [ROW_WIDTH:0]   brk;
    logic [ROW_WIDTH-1:0] rest;
    logic [EW-1:0]        k_start;
    logic [EW-1:0]        k_end;
    logic [MW-1:0]        c_start;
    logic [MW-1:0]        c_end;
    logic                 last;

    assign take     = !r_out_valid || i_pop;
    assign step     = take && ((r_state == S_RUN) || !i_q_empty);
    assign o_q_pop  = take && (r_state == S_IDLE) && !i_q_empty;

    assign src      = (r_state == S_RUN) ? r_vec  : i_vec;
    assign src_rev  = (r_state == S_RUN) ? r_rev  : i_rev;
    assign src_cols = (r_state == S_RUN) ? r_cols : i_cols;
    assign src_row  = (r_state == S_RUN) ? r_row  : i_row;
    assign src_cnt  = (r_state == S_RUN) ? r_cnt  : '0;

    // Adding the lowest set bit clears the first run and sets the bit after it.
    assign low_bit  = src & (~src + ROW_WIDTH'(1));
    assign sum      = {1'b0, src} + {1'b0, low_bit};
    assign brk      = sum & ~{1'b0, src};
    assign rest     = src & sum[ROW_WIDTH-1:0];

    always_comb begin
        k_start = '0;
        k_end   = '0;
        for (int i = 0; i < ROW_WIDTH; i++) begin
            if (low_bit[i]) begin
                k_start = k_start | EW'(i);
            end
        end
        for (int i = 0; i <= ROW_WIDTH; i++) begin
            if (brk[i]) begin
                k_end = k_end | EW'(i);
            end
        end
        k_end = k_end - EW'(1);
    end

    assign c_start = src_rev ? (MW'(src_cols) - MW'(1) - MW'(k_start)) : MW'(k_start);
    assign c_end   = src_rev ? (MW'(src_cols) - MW'(1) - MW'(k_end))   : MW'(k_end);
    assign last    = (rest == '0) || (src_cnt == SEG_CNT_W'(MAX_SEGS - 1));

    assign o_empty = !r_out_valid;
    assign o_seg   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (step) begin
                r_out_valid        <= 1'b1;
                r_out.row_index    <= src_row;
                r_out.start_col    <= c_start[COL_OUT_W-1:0];
                r_out.end_col      <= c_end[COL_OUT_W-1:0];
                r_out.last_segment <= last;
                r_vec              <= rest;
                r_rev              <= src_rev;
                r_cols             <= src_cols;
                r_row              <= src_row;
                r_cnt              <= src_cnt + SEG_CNT_W'(1);
                r_state            <= last ? S_IDLE : S_RUN;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/serpentine_run_segment_extractor_top.sv =====
// ----------------------------------------------------------------------------
// serpentine_run_segment_extractor_top
// Serpentine run segment extractor: one bitmap row in, one segment out per
// run of set pixels, scanned alternately left to right and right to left.
//
//   Channel  Handshake           Payload
//   -------  ------------------  --------------------------------------------
//   row in   push / full         i_row_bits
//   segment  empty / pop         o_row_index, o_start_col, o_end_col,
//                                o_last_segment
//   config   i_cfg_valid/ready   i_cfg_index, i_cfg_data
//
// The extractor turns a row with n runs into n segments, at most 16, one run
// per cycle while the output is not stalled; an empty row is retired in its
// accept cycle and never reaches the extractor.
// The classifier takes a row each cycle while the two-entry queue has room.
// Both sides stall independently; the output register holds a segment until
// it is popped. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module serpentine_run_segment_extractor_top
    import srse_pkg::*;
#(
    parameter int ROW_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [IN_BITS_W-1:0]  i_row_bits,
    output logic                  empty,
    input  logic                  pop,
    output logic [ROW_IDX_W-1:0]  o_row_index,
    output logic [COL_OUT_W-1:0]  o_start_col,
    output logic [COL_OUT_W-1:0]  o_end_col,
    output logic                  o_last_segment,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EW = $clog2(ROW_WIDTH + 1);
    localparam int QW = ROW_WIDTH + 1 + EW + ROW_IDX_W;

    logic                 accept;
    logic                 f_push;
    logic [ROW_WIDTH-1:0] f_vec;
    logic                 f_rev;
    logic [EW-1:0]        f_cols;
    logic [ROW_IDX_W-1:0] f_row;
    logic [QW-1:0]        q_head;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    t_seg                 seg;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    srse_front #(
        .ROW_WIDTH (ROW_WIDTH),
        .EW        (EW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_row_bits  (i_row_bits),
        .o_q_push    (f_push),
        .o_vec       (f_vec),
        .o_rev       (f_rev),
        .o_cols      (f_cols),
        .o_row       (f_row)
    );

    srse_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_vec, f_rev, f_cols, f_row}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    srse_back #(
        .ROW_WIDTH (ROW_WIDTH),
        .EW        (EW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_vec     (q_head[QW-1 -: ROW_WIDTH]),
        .i_rev     (q_head[EW + ROW_IDX_W]),
        .i_cols    (q_head[ROW_IDX_W +: EW]),
        .i_row     (q_head[ROW_IDX_W-1:0]),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_seg     (seg)
    );

    assign o_row_index    = seg.row_index;
    assign o_start_col    = seg.start_col;
    assign o_end_col      = seg.end_col;
    assign o_last_segment = seg.last_segment;

endmodule

// ===== sv/srse_checker.sv =====
// ----------------------------------------------------------------------------
// srse_checker
// Port-level checks of the serpentine run segment extractor.
// ----------------------------------------------------------------------------
module srse_checker
    import srse_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [ROW_IDX_W-1:0] o_row_index,
    input logic [COL_OUT_W-1:0] o_start_col,
    input logic [COL_OUT_W-1:0] o_end_col,
    input logic                 o_last_segment
);

    logic                 r_mid;
    logic [ROW_IDX_W-1:0] r_mid_row;

    // Tracks whether the last popped segment left its row unfinished.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (pop && !empty) begin
            r_mid     <= !o_last_segment;
            r_mid_row <= o_row_index;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row_index) && $stable(o_start_col)
                              && $stable(o_end_col) && $stable(o_last_segment)))
        else $error("segment changed while stalled");

    a_row_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid && !empty) |-> (o_row_index == r_mid_row))
        else $error("segments of one row interleaved with another row");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("queue flags wrong after reset");

    a_full_stalls_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !empty && !pop) |=> full)
        else $error("full dropped while the extractor was stalled");

endmodule

bind serpentine_run_segment_extractor_top srse_checker u_srse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_row_index    (o_row_index),
    .o_start_col    (o_start_col),
    .o_end_col      (o_end_col),
    .o_last_segment (o_last_segment)
);
